// ----- design/gsm_pkg.sv -----
// Shared constants, register codes and compare helpers of the grayscale morphology core.
package gsm_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MODE_W     = 1;
  localparam int RADIUS_W   = 3;
  localparam int FWIDTH_W   = 11;
  localparam int FHEIGHT_W  = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  localparam logic [MODE_W-1:0]    MODE_RST    = 1'b0;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 3'd1;
  localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 13'd480;

  // Neutral element of the reduction: zero for maximum, all ones for minimum.
  function automatic logic [PIX_W-1:0] ident(input logic mn);
    ident = mn ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
  endfunction

  function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic mn);
    if (mn) pick = (a < b) ? a : b;
    else    pick = (a > b) ? a : b;
  endfunction

endpackage

// ----- design/gsm_in_if.sv -----
// Input channel of the morphology core: valid/ready with pixel payload.
interface gsm_in_if;
  import gsm_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, kind, pixel_in, input ready);
  modport sink   (input valid, kind, pixel_in, output ready);
endinterface

// ----- design/gsm_out_if.sv -----
// Result channel of the morphology core: valid/ready with filtered pixel payload.
interface gsm_out_if;
  import gsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;
  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

// ----- design/grayscale_square_morphology_core.sv -----
// Top level of the square-window grayscale dilation/erosion core.
//
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid/ready      | kind, pixel_in
//   out_ch   | out | valid/ready      | pixel_out, frame_last
//   cfg_*    | in  | cfg_we (no wait) | cfg_index, cfg_wdata
//
// One item is taken per clock unless a result is stalled; a result is offered on
// out_ch once the emit tag of its item has passed e1, e2, e3, e4 and the output
// register. The row window is a chain of 2*RADIUS_MAX+1 taps, and the column pass
// reads the same column of every line store at once, one store per line.
// Synchronous reset clears counters and valid flags, loads configuration defaults
// and keeps line stores. A stalled result holds the whole pipeline and in_ch.ready.
module grayscale_square_morphology_core #(
  parameter int RADIUS_MAX = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gsm_in_if.sink                         in_ch,
  gsm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  gsm_pkg::cfg_idx_t              cfg_index,
  input  logic [gsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gsm_pkg::*;

  localparam int LINES = 2 * RADIUS_MAX + 1;
  localparam int SW    = $clog2(LINES);
  localparam int PW    = $clog2(LINES);
  localparam int RW    = $clog2(RADIUS_MAX + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int TL    = $clog2(LINES);
  localparam int TREE  = 1 << TL;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic [CW-1:0] pc;
    logic [HW-1:0] pr;
    logic [SW-1:0] pslot;
  } emit_t;

  function automatic logic [PIX_W-1:0] reduce(input logic [PIX_W-1:0] v [LINES],
                                              input logic mn);
    logic [PIX_W-1:0] t [TREE];
    for (int i = 0; i < TREE; i++) begin
      if (i < LINES) t[i] = v[i];
      else           t[i] = ident(mn);
    end
    for (int lv = 0; lv < TL; lv++) begin
      for (int i = 0; i < (TREE >> (lv + 1)); i++) begin
        t[i] = pick(t[2*i], t[2*i+1], mn);
      end
    end
    reduce = t[0];
  endfunction

  // Configuration.
  logic [MODE_W-1:0]    mode_r;
  logic [RADIUS_W-1:0]  radius_r;
  logic [FWIDTH_W-1:0]  width_r;
  logic [FHEIGHT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      radius_r <= RADIUS_RST;
      width_r  <= FWIDTH_RST;
      height_r <= FHEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_RADIUS: radius_r <= cfg_wdata[RADIUS_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[FWIDTH_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [RW-1:0] r_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [PW-1:0] m_eff;
  logic [NW-1:0] lag;
  logic [NW-1:0] n_tot;
  logic [CW-1:0] col_last;

  always_comb begin
    r_eff = (int'(radius_r) > RADIUS_MAX) ? RW'(RADIUS_MAX) : RW'(radius_r);
    if (width_r == '0)                   w_eff = WW'(1);
    else if (int'(width_r) > MAX_WIDTH)  w_eff = WW'(MAX_WIDTH);
    else                                 w_eff = WW'(width_r);
    if (height_r == '0)                  h_eff = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                                 h_eff = HW'(height_r);
    col_last = CW'(int'(w_eff) - 1);
    // The center tap sits min(radius, W-1) behind the newest pixel.
    m_eff = (int'(r_eff) < int'(w_eff) - 1) ? PW'(r_eff) : PW'(int'(w_eff) - 1);
    lag   = NW'(int'(r_eff) * int'(w_eff) + int'(m_eff));
    n_tot = NW'(int'(w_eff) * int'(h_eff));
  end

  // Pipeline advance: everything moves unless a result waits at the output.
  logic out_valid_r;
  logic en;
  logic acc;
  assign en  = !out_valid_r || out_ch.ready;
  assign acc = in_ch.valid && en;
  assign in_ch.ready = en;

  // Frame counters.
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [SW-1:0] rslot_r, rslot_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic [NW-1:0] emitted_r, emitted_nxt;
  logic [CW-1:0] epc_r, epc_nxt;
  logic [HW-1:0] epr_r, epr_nxt;
  logic [SW-1:0] epslot_r, epslot_nxt;
  logic          frame_done;
  logic          shift;
  logic          emit;
  logic          clear;
  logic          last;
  logic          new_valid;
  emit_t         e1_nxt;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    rslot_nxt   = rslot_r;
    k_nxt       = k_r;
    emitted_nxt = emitted_r;
    epc_nxt     = epc_r;
    epr_nxt     = epr_r;
    epslot_nxt  = epslot_r;
    frame_done  = row_r >= h_eff;
    shift       = 1'b0;
    emit        = 1'b0;
    clear       = 1'b0;
    new_valid   = 1'b0;
    if (acc) begin
      if (frame_done) begin
        // Items after the last pixel push blanks through the window.
        shift = 1'b1;
        if (emitted_r < n_tot) emit = 1'b1;
        else                   clear = 1'b1;
      end else if (!in_ch.kind) begin
        shift     = 1'b1;
        new_valid = 1'b1;
        k_nxt     = k_r + NW'(1);
        if (int'(col_r) + 1 >= int'(w_eff)) begin
          col_nxt   = '0;
          row_nxt   = row_r + HW'(1);
          rslot_nxt = (rslot_r == SW'(LINES - 1)) ? '0 : rslot_r + SW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
        if (({1'b0, k_r} >= {1'b0, lag} + {1'b0, emitted_r}) && (emitted_r < n_tot)) begin
          emit = 1'b1;
        end
      end
    end
    last = ({1'b0, emitted_r} + (NW+1)'(1)) >= {1'b0, n_tot};
    if (emit) begin
      if (last) begin
        clear = 1'b1;
      end else begin
        emitted_nxt = emitted_r + NW'(1);
        if (int'(epc_r) + 1 >= int'(w_eff)) begin
          epc_nxt    = '0;
          epr_nxt    = epr_r + HW'(1);
          epslot_nxt = (epslot_r == SW'(LINES - 1)) ? '0 : epslot_r + SW'(1);
        end else begin
          epc_nxt = epc_r + CW'(1);
        end
      end
    end
    if (clear) begin
      col_nxt     = '0;
      row_nxt     = '0;
      rslot_nxt   = '0;
      k_nxt       = '0;
      emitted_nxt = '0;
      epc_nxt     = '0;
      epr_nxt     = '0;
      epslot_nxt  = '0;
    end
    e1_nxt.valid = emit;
    e1_nxt.last  = last;
    e1_nxt.pc    = epc_r;
    e1_nxt.pr    = epr_r;
    e1_nxt.pslot = epslot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      rslot_r   <= '0;
      k_r       <= '0;
      emitted_r <= '0;
      epc_r     <= '0;
      epr_r     <= '0;
      epslot_r  <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      rslot_r   <= rslot_nxt;
      k_r       <= k_nxt;
      emitted_r <= emitted_nxt;
      epc_r     <= epc_nxt;
      epr_r     <= epr_nxt;
      epslot_r  <= epslot_nxt;
    end
  end

  // Row window chain.
  logic             cv     [LINES];
  logic [CW-1:0]    ccol   [LINES];
  logic [SW-1:0]    cslot  [LINES];
  logic [PIX_W-1:0] cpix   [LINES];
  logic [PIX_W-1:0] contrib [LINES];
  logic [CW-1:0]    center_col;

  assign center_col = ccol[m_eff];

  for (genvar i = 0; i < LINES; i++) begin : g_tap
    logic             pv;
    logic [CW-1:0]    pcol;
    logic [SW-1:0]    pslot;
    logic [PIX_W-1:0] ppix;
    if (i == 0) begin : g_head
      assign pv    = new_valid;
      assign pcol  = col_r;
      assign pslot = rslot_r;
      assign ppix  = in_ch.pixel_in;
    end else begin : g_link
      assign pv    = cv[i-1];
      assign pcol  = ccol[i-1];
      assign pslot = cslot[i-1];
      assign ppix  = cpix[i-1];
    end
    gsm_cell #(
      .POS (i),
      .CW  (CW),
      .SW  (SW),
      .RW  (RW),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (shift),
      .prev_valid (pv),
      .prev_col   (pcol),
      .prev_slot  (pslot),
      .prev_pix   (ppix),
      .center_m   (m_eff),
      .center_col (center_col),
      .col_last   (col_last),
      .r_eff      (r_eff),
      .mode       (mode_r),
      .cur_valid  (cv[i]),
      .cur_col    (ccol[i]),
      .cur_slot   (cslot[i]),
      .cur_pix    (cpix[i]),
      .contrib    (contrib[i])
    );
  end

  // Pipeline registers.
  logic             pend_r;
  logic             wr_valid_r;
  logic [CW-1:0]    wr_col_r;
  logic [SW-1:0]    wr_slot_r;
  logic [PIX_W-1:0] filt_r;
  emit_t            e1_r, e2_r, e3_r;
  logic             e4_valid_r;
  logic             e4_last_r;
  logic [LINES-1:0] e4_mask_r;
  logic [LINES-1:0] mask_nxt;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;
  logic [PIX_W-1:0] rdata [LINES];
  logic [PIX_W-1:0] col_vals [LINES];

  // A line slot takes part when its row lies within radius of the output row
  // and inside the frame.
  always_comb begin
    int off;
    int back;
    for (int s = 0; s < LINES; s++) begin
      off = s + LINES - int'(e3_r.pslot);
      if (off >= LINES) off = off - LINES;
      back = LINES - off;
      if (off <= RADIUS_MAX) begin
        mask_nxt[s] = (off <= int'(r_eff)) && (int'(e3_r.pr) + off <= int'(h_eff) - 1);
      end else begin
        mask_nxt[s] = (back <= int'(r_eff)) && (back <= int'(e3_r.pr));
      end
    end
  end

  always_comb begin
    for (int s = 0; s < LINES; s++) begin
      col_vals[s] = e4_mask_r[s] ? rdata[s] : ident(mode_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      wr_valid_r  <= 1'b0;
      e1_r.valid  <= 1'b0;
      e2_r.valid  <= 1'b0;
      e3_r.valid  <= 1'b0;
      e4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pend_r      <= shift;
      wr_valid_r  <= pend_r && cv[m_eff];
      e1_r.valid  <= e1_nxt.valid;
      e2_r.valid  <= e1_r.valid;
      e3_r.valid  <= e2_r.valid;
      e4_valid_r  <= e3_r.valid;
      out_valid_r <= e4_valid_r;
    end
    if (en) begin
      wr_col_r   <= center_col;
      wr_slot_r  <= cslot[m_eff];
      filt_r     <= reduce(contrib, mode_r);
      e1_r.last  <= e1_nxt.last;
      e1_r.pc    <= e1_nxt.pc;
      e1_r.pr    <= e1_nxt.pr;
      e1_r.pslot <= e1_nxt.pslot;
      e2_r.last  <= e1_r.last;
      e2_r.pc    <= e1_r.pc;
      e2_r.pr    <= e1_r.pr;
      e2_r.pslot <= e1_r.pslot;
      e3_r.last  <= e2_r.last;
      e3_r.pc    <= e2_r.pc;
      e3_r.pr    <= e2_r.pr;
      e3_r.pslot <= e2_r.pslot;
      e4_last_r  <= e3_r.last;
      e4_mask_r  <= mask_nxt;
      out_last_r <= e4_last_r;
      out_pix_r  <= reduce(col_vals, mode_r);
    end
  end

  // Line stores, one per row of the column window.
  for (genvar s = 0; s < LINES; s++) begin : g_line
    gsm_line #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
    ) u_line (
      .clk   (clk),
      .we    (en && wr_valid_r && (wr_slot_r == SW'(s))),
      .waddr (wr_col_r),
      .wdata (filt_r),
      .re    (en),
      .raddr (e3_r.pc),
      .rdata (rdata[s])
    );
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_out  = out_pix_r;
  assign out_ch.frame_last = out_last_r;

endmodule

// ----- design/gsm_line.sv -----
// One row-filtered line store: single write port, single registered read port.
module gsm_line #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [gsm_pkg::PIX_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [gsm_pkg::PIX_W-1:0] rdata
);
  import gsm_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/gsm_cell.sv -----
// One tap of the row window: holds a pixel with its column and line tag and
// offers it to the row reduction when it lies inside the clipped window.
module gsm_cell #(
  parameter int POS = 0,
  parameter int CW  = 10,
  parameter int SW  = 4,
  parameter int RW  = 3,
  parameter int PW  = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic                      prev_valid,
  input  logic [CW-1:0]             prev_col,
  input  logic [SW-1:0]             prev_slot,
  input  logic [gsm_pkg::PIX_W-1:0] prev_pix,
  input  logic [PW-1:0]             center_m,
  input  logic [CW-1:0]             center_col,
  input  logic [CW-1:0]             col_last,
  input  logic [RW-1:0]             r_eff,
  input  logic                      mode,
  output logic                      cur_valid,
  output logic [CW-1:0]             cur_col,
  output logic [SW-1:0]             cur_slot,
  output logic [gsm_pkg::PIX_W-1:0] cur_pix,
  output logic [gsm_pkg::PIX_W-1:0] contrib
);
  import gsm_pkg::*;

  logic             valid_r;
  logic [CW-1:0]    col_r;
  logic [SW-1:0]    slot_r;
  logic [PIX_W-1:0] pix_r;
  logic             incl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= prev_valid;
    end
    if (shift) begin
      col_r  <= prev_col;
      slot_r <= prev_slot;
      pix_r  <= prev_pix;
    end
  end

  // Newer taps belong to the center's row while they stay left of the row end;
  // older taps while within the radius and the column does not run below zero.
  always_comb begin
    incl = 1'b0;
    if (POS < int'(center_m)) begin
      incl = (int'(center_col) + int'(center_m) - POS) <= int'(col_last);
    end else if (POS == int'(center_m)) begin
      incl = 1'b1;
    end else begin
      incl = ((POS - int'(center_m)) <= int'(r_eff)) &&
             (int'(center_col) >= (POS - int'(center_m)));
    end
    contrib = (valid_r && incl) ? pix_r : ident(mode);
  end

  assign cur_valid = valid_r;
  assign cur_col   = col_r;
  assign cur_slot  = slot_r;
  assign cur_pix   = pix_r;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the grayscale square-window morphology core.
`timescale 1ns / 100ps

module testbench;
  import gsm_pkg::*;

  localparam int WIN_TAPS = 15;
  localparam int LINE_LEN = 1024;
  localparam int RAD_MAX  = 7;
  localparam int HGT_MAX  = 4096;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } morph_result_t;

  // Scoreboard with its own copy of the two-pass filter state.
  class morph_scoreboard;
    bit                   mode;
    bit [RADIUS_W-1:0]    radius;
    bit [FWIDTH_W-1:0]    fwidth;
    bit [FHEIGHT_W-1:0]   fheight;
    logic [PIX_W-1:0]     lines [WIN_TAPS*LINE_LEN];
    logic [PIX_W-1:0]     taps [WIN_TAPS];
    int unsigned          col_cnt, row_cnt, out_cnt;
    morph_result_t        expected_pixels [$];
    int                   errors, results_seen, items_seen;

    function void reset_state();
      mode = MODE_RST; radius = RADIUS_RST; fwidth = FWIDTH_RST; fheight = FHEIGHT_RST;
      foreach (lines[i]) lines[i] = '0;
      foreach (taps[i]) taps[i] = '0;
      col_cnt = 0; row_cnt = 0; out_cnt = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_MODE:   mode = v[0];
        CFG_RADIUS: radius = v[RADIUS_W-1:0];
        CFG_WIDTH:  fwidth = v[FWIDTH_W-1:0];
        CFG_HEIGHT: fheight = v[FHEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_r();
      return (radius > RAD_MAX) ? RAD_MAX : radius;
    endfunction
    function int unsigned eff_w();
      if (fwidth == 0) return 1;
      return (fwidth > LINE_LEN) ? LINE_LEN : fwidth;
    endfunction
    function int unsigned eff_h();
      if (fheight == 0) return 1;
      return (fheight > HGT_MAX) ? HGT_MAX : fheight;
    endfunction

    function logic [PIX_W-1:0] sel(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      if (mode) return (a < b) ? a : b;
      return (a > b) ? a : b;
    endfunction

    // Horizontal max/min for column c, given the newest pixel sits at column col.
    function void filter_col(int unsigned col, int unsigned c, int unsigned r,
                             int unsigned w);
      int unsigned hi, lo, jlo, jhi;
      logic [PIX_W-1:0] acc;
      hi = c + r;
      lo = (c > r) ? c - r : 0;
      if (hi > w - 1) hi = w - 1;
      if (hi > col) hi = col;
      if (c >= LINE_LEN || lo > hi) return;
      jlo = col - hi;
      jhi = col - lo;
      if (jhi > WIN_TAPS - 1) jhi = WIN_TAPS - 1;
      acc = taps[(jlo < WIN_TAPS) ? jlo : WIN_TAPS - 1];
      for (int unsigned j = jlo; j <= jhi; j++) acc = sel(acc, taps[j]);
      lines[(row_cnt % WIN_TAPS) * LINE_LEN + c] = acc;
    endfunction

    // Vertical pass over the line ring for the next output pixel.
    function void column_pass(int unsigned r, int unsigned w, int unsigned h);
      int unsigned n, pr, pc, lo, hi;
      morph_result_t res;
      n = w * h;
      pr = out_cnt / w;
      pc = out_cnt % w;
      lo = (pr > r) ? pr - r : 0;
      hi = pr + r;
      if (hi > h - 1) hi = h - 1;
      res.pixel = lines[(lo % WIN_TAPS) * LINE_LEN + pc];
      for (int unsigned rr = lo; rr <= hi; rr++)
        res.pixel = sel(res.pixel, lines[(rr % WIN_TAPS) * LINE_LEN + pc]);
      res.last = (out_cnt + 1 >= n);
      expected_pixels.insert(expected_pixels.size(), res);
      if (res.last) begin
        col_cnt = 0; row_cnt = 0; out_cnt = 0;
      end else begin
        out_cnt++;
      end
    endfunction

    function void note_item(bit kind, logic [PIX_W-1:0] pix);
      int unsigned r, w, h, n, lag, col, k;
      r = eff_r(); w = eff_w(); h = eff_h();
      n = w * h;
      lag = r * w + ((r < w - 1) ? r : w - 1);
      items_seen++;
      if (row_cnt >= h) begin
        if (out_cnt < n) column_pass(r, w, h);
        else begin
          col_cnt = 0; row_cnt = 0; out_cnt = 0;
        end
        return;
      end
      if (kind) return;
      col = col_cnt;
      for (int i = WIN_TAPS - 1; i > 0; i--) taps[i] = taps[i-1];
      taps[0] = pix;
      if (col >= r) filter_col(col, col - r, r, w);
      if (col == w - 1)
        for (int unsigned c = (col >= r) ? col - r + 1 : 0; c < w; c++)
          filter_col(col, c, r, w);
      k = row_cnt * w + col;
      col_cnt = col + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (k >= lag + out_cnt && out_cnt < n) column_pass(r, w, h);
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic last);
      morph_result_t exp_res;
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %0d frame_last %0d", pix, last);
        errors++;
        return;
      end
      exp_res = expected_pixels.pop_front();
      if (pix !== exp_res.pixel) begin
        $error("pixel_out mismatch: expected %0d actual %0d", exp_res.pixel, pix);
        errors++;
      end
      if (last !== exp_res.last) begin
        $error("frame_last mismatch: expected %0d actual %0d", exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gsm_in_if  in_ch ();
  gsm_out_if out_ch ();

  grayscale_square_morphology_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  morph_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int frames_run;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("testbench failed");
    $finish;
  end

  // Result side: check accepted items, then choose next ready.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.pixel_out, out_ch.frame_last);
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(bit kind, logic [PIX_W-1:0] pix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.pixel_in <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(kind, pix);
  endtask

  // Holds the write enable high; the caller lowers it after the last write.
  task automatic write_reg(cfg_idx_t idx, int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, v[CFG_DATA_W-1:0]);
  endtask

  // Waits until the core has nothing left in flight, then loads all registers.
  task automatic configure(bit md, int unsigned r, int unsigned wreg, int unsigned hreg);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_reg(CFG_MODE, md);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_WIDTH, wreg);
    write_reg(CFG_HEIGHT, hreg);
    cfg_we <= 1'b0;
  endtask

  // One full frame: pixels with stray drains mixed in, then the flush items.
  task automatic run_frame(bit md, int unsigned r, int unsigned wreg, int unsigned hreg,
                           int noise_pct);
    int unsigned w, h, n, lag, flush;
    configure(md, r, wreg, hreg);
    w = sb.eff_w();
    h = sb.eff_h();
    n = w * h;
    lag = r * w + ((r < w - 1) ? r : w - 1);
    flush = (lag < n) ? lag : n;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(1'b1, PIX_W'($urandom_range(255)));
      send_item(1'b0, PIX_W'($urandom_range(255)));
    end
    // A pixel arriving after the frame's last pixel flushes like a drain.
    repeat (flush) send_item($urandom_range(99) < 80, PIX_W'($urandom_range(255)));
    frames_run++;
  endtask

  initial begin
    int sent_random;
    sb = new();
    sb.reset_state();
    sb.errors = 0; sb.results_seen = 0; sb.items_seen = 0;
    frames_run = 0;
    send_idle_pct = 13;
    recv_idle_pct = 46;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.pixel_in = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero radius passes pixels straight through; extremes and a stray drain.
    configure(1'b0, 0, 4, 2);
    send_item(1'b0, 8'd0);
    send_item(1'b1, 8'd255);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'h55);
    send_item(1'b0, 8'hAA);
    repeat (4) send_item(1'b0, PIX_W'($urandom_range(255)));

    // Erosion on a 3x3 frame with a pixel used as a flush item.
    configure(1'b1, 1, 3, 3);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd0);
    repeat (7) send_item(1'b0, PIX_W'($urandom_range(255)));
    send_item(1'b0, 8'd17);
    repeat (3) send_item(1'b1, 8'd0);

    // Shrinking the height mid-frame leaves nothing pending: the drain only clears.
    configure(1'b0, 0, 4, 5);
    repeat (8) send_item(1'b0, PIX_W'($urandom_range(255)));
    configure(1'b0, 0, 4, 2);
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd9);
    send_item(1'b1, 8'd0);
    repeat (7) send_item(1'b0, PIX_W'($urandom_range(255)));

    // Zero width and height read as one; largest radius.
    run_frame(1'b1, 7, 0, 0, 0);

    // Random frames, mostly small, with the idling pattern changing by thirds.
    sent_random = 0;
    while (sent_random < 450) begin
      int unsigned items_before;
      if (sent_random < 150) begin
        send_idle_pct = 13; recv_idle_pct = 46;
      end else if (sent_random < 300) begin
        send_idle_pct = 46; recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      items_before = sb.items_seen;
      run_frame(1'($urandom_range(1)), $urandom_range(7), $urandom_range(20, 1),
                $urandom_range(12, 1), 5);
      sent_random += sb.items_seen - items_before;
    end

    // A long receiver hold-off fills the core and stalls its input.
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_req = 1'b1;
    run_frame(1'($urandom_range(1)), 7, 16, 8, 2);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d items sent over %0d frames, %0d results checked.",
             sb.items_seen, frames_run, sb.results_seen);
    $display("Covered both modes, radii 0 to 7, zero sizes, mid-frame shrink and a long stall.");
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
